// ----- rtl/irpdt_pkg.sv -----
package irpdt_pkg;

  localparam int CODE_BITS = 32;
  localparam int KEY_W     = 32;
  localparam int LEN_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int BIT_IDX_W = $clog2(CODE_BITS + 1);
  localparam int SEL_W     = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;

  // bit index value that marks the header part of the frame
  localparam logic [BIT_IDX_W-1:0] HDR_IDX  = BIT_IDX_W'(CODE_BITS);
  localparam logic [BIT_IDX_W-1:0] LAST_IDX = BIT_IDX_W'(CODE_BITS - 1);

  // input op codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SEND = 1'b1;

  localparam logic [LEN_W-1:0] HEADER_HIGH_RST = 16'd9000;
  localparam logic [LEN_W-1:0] HEADER_LOW_RST  = 16'd4500;
  localparam logic [LEN_W-1:0] MARK_RST        = 16'd560;
  localparam logic [LEN_W-1:0] ONE_RST         = 16'd1690;
  localparam logic [LEN_W-1:0] ZERO_RST        = 16'd560;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_HIGH = 3'd0,
    REG_HEADER_LOW  = 3'd1,
    REG_MARK        = 3'd2,
    REG_ONE         = 3'd3,
    REG_ZERO        = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    SEG_HDR_HIGH = 4'b0001,
    SEG_HDR_LOW  = 4'b0010,
    SEG_DATA     = 4'b0100,
    SEG_MARK     = 4'b1000
  } seg_t;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] keycode;
  } in_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic send_rejected;
  } out_t;

  typedef struct packed {
    logic [LEN_W-1:0] header_high_len;
    logic [LEN_W-1:0] header_low_len;
    logic [LEN_W-1:0] mark_len;
    logic [LEN_W-1:0] one_len;
    logic [LEN_W-1:0] zero_len;
  } cfg_regs_t;

endpackage

// ----- rtl/ir_pulse_distance_transmitter_core.sv -----
// channel | ports                                    | direction
// input   | in_valid, in_ready, in_data (op, keycode)| into the block
// result  | out_valid, out_ready, out_data           | out of the block
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data| into the block
//
// one input transfer per cycle while the result is taken, one result per input, registered in the
// next cycle; the frame state update and the segment compare are combinational
// ahead of the result register.
// reset (synchronous, active low) clears the frame state and the result valid
// flag and loads the default segment lengths.
// a full result register that is not taken holds in_ready low; config writes
// are always accepted.
module ir_pulse_distance_transmitter_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  irpdt_pkg::in_t                  in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output irpdt_pkg::out_t                 out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [irpdt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irpdt_pkg::LEN_W-1:0]     cfg_data
);

  irpdt_pkg::cfg_regs_t regs;
  irpdt_pkg::out_t      res;
  irpdt_pkg::out_t      out_data_r;
  logic                 out_valid_r, out_valid_nxt;
  logic                 in_xfer;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~out_valid_r | out_ready;
  assign in_xfer   = in_valid & in_ready;

  irpdt_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (regs)
  );

  irpdt_frame u_frame (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (in_xfer),
    .item  (in_data),
    .regs  (regs),
    .res   (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/irpdt_cfg.sv -----
module irpdt_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [irpdt_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [irpdt_pkg::LEN_W-1:0]     wr_data,
  output irpdt_pkg::cfg_regs_t            regs
);

  irpdt_pkg::cfg_regs_t regs_r;
  irpdt_pkg::cfg_regs_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      case (wr_index)
        irpdt_pkg::REG_HEADER_HIGH: regs_nxt.header_high_len = wr_data;
        irpdt_pkg::REG_HEADER_LOW:  regs_nxt.header_low_len  = wr_data;
        irpdt_pkg::REG_MARK:        regs_nxt.mark_len        = wr_data;
        irpdt_pkg::REG_ONE:         regs_nxt.one_len         = wr_data;
        irpdt_pkg::REG_ZERO:        regs_nxt.zero_len        = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.header_high_len <= irpdt_pkg::HEADER_HIGH_RST;
      regs_r.header_low_len  <= irpdt_pkg::HEADER_LOW_RST;
      regs_r.mark_len        <= irpdt_pkg::MARK_RST;
      regs_r.one_len         <= irpdt_pkg::ONE_RST;
      regs_r.zero_len        <= irpdt_pkg::ZERO_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

// ----- rtl/irpdt_frame.sv -----
module irpdt_frame (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  irpdt_pkg::in_t       item,
  input  irpdt_pkg::cfg_regs_t regs,
  output irpdt_pkg::out_t      res
);

  irpdt_pkg::seg_t                  seg_r, seg_nxt;
  logic [irpdt_pkg::BIT_IDX_W-1:0]  bit_idx_r, bit_idx_nxt;
  logic [irpdt_pkg::LEN_W-1:0]      tick_r, tick_nxt;
  logic [irpdt_pkg::CODE_BITS-1:0]  shift_r, shift_nxt;
  logic                             line_r, line_nxt;
  logic                             busy_r, busy_nxt;
  logic                             rejected;
  logic [irpdt_pkg::LEN_W-1:0]      seg_len;
  logic                             cur_bit;

  assign cur_bit = shift_r[bit_idx_r[irpdt_pkg::SEL_W-1:0]];

  always_comb begin
    case (seg_r)
      irpdt_pkg::SEG_HDR_HIGH: seg_len = regs.header_high_len;
      irpdt_pkg::SEG_HDR_LOW:  seg_len = regs.header_low_len;
      irpdt_pkg::SEG_DATA:     seg_len = cur_bit ? regs.one_len : regs.zero_len;
      irpdt_pkg::SEG_MARK:     seg_len = regs.mark_len;
      default:                 seg_len = regs.mark_len;
    endcase
  end

  always_comb begin
    seg_nxt     = seg_r;
    bit_idx_nxt = bit_idx_r;
    tick_nxt    = tick_r;
    shift_nxt   = shift_r;
    line_nxt    = line_r;
    busy_nxt    = busy_r;
    rejected    = 1'b0;
    if (step) begin
      if (item.op == irpdt_pkg::OP_SEND) begin
        if (busy_r) begin
          rejected = 1'b1;
        end else begin
          shift_nxt   = item.keycode[irpdt_pkg::CODE_BITS-1:0];
          busy_nxt    = 1'b1;
          bit_idx_nxt = irpdt_pkg::HDR_IDX;
          seg_nxt     = irpdt_pkg::SEG_HDR_HIGH;
          tick_nxt    = '0;
          line_nxt    = 1'b1;
        end
      end else if (busy_r) begin
        if (tick_r == seg_len) begin
          tick_nxt = '0;
          line_nxt = ~line_r;
          case (seg_r)
            irpdt_pkg::SEG_HDR_HIGH: seg_nxt = irpdt_pkg::SEG_HDR_LOW;
            irpdt_pkg::SEG_HDR_LOW:  seg_nxt = irpdt_pkg::SEG_MARK;
            irpdt_pkg::SEG_DATA:     seg_nxt = irpdt_pkg::SEG_MARK;
            irpdt_pkg::SEG_MARK: begin
              if (bit_idx_r == irpdt_pkg::HDR_IDX) begin
                // header mark done, first data bit next
                bit_idx_nxt = irpdt_pkg::LAST_IDX;
                seg_nxt     = irpdt_pkg::SEG_DATA;
              end else if (bit_idx_r == '0) begin
                // trailing mark done, frame ends with the line low
                bit_idx_nxt = irpdt_pkg::HDR_IDX;
                seg_nxt     = irpdt_pkg::SEG_HDR_HIGH;
                busy_nxt    = 1'b0;
                shift_nxt   = '0;
                line_nxt    = 1'b0;
              end else begin
                bit_idx_nxt = bit_idx_r - 1'b1;
                seg_nxt     = irpdt_pkg::SEG_DATA;
              end
            end
            default: seg_nxt = irpdt_pkg::SEG_HDR_HIGH;
          endcase
        end else begin
          tick_nxt = tick_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r     <= irpdt_pkg::SEG_HDR_HIGH;
      bit_idx_r <= irpdt_pkg::HDR_IDX;
      tick_r    <= '0;
      shift_r   <= '0;
      line_r    <= 1'b0;
      busy_r    <= 1'b0;
    end else begin
      seg_r     <= seg_nxt;
      bit_idx_r <= bit_idx_nxt;
      tick_r    <= tick_nxt;
      shift_r   <= shift_nxt;
      line_r    <= line_nxt;
      busy_r    <= busy_nxt;
    end
  end

  assign res.line_level    = line_nxt;
  assign res.busy_res      = busy_nxt;
  assign res.send_rejected = rejected;

endmodule

// ----- rtl/irpdt_checker.sv -----
module irpdt_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input irpdt_pkg::in_t  in_data,
  input logic            out_valid,
  input logic            out_ready,
  input irpdt_pkg::out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // every input transfer shows a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("input transfer without result");

  // a send, taken or refused, leaves the block busy
  a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.op == irpdt_pkg::OP_SEND |=>
      out_valid && out_data.busy_res)
    else $error("send did not leave block busy");

  // idle line is low and a refusal only happens while busy
  a_idle_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.busy_res |-> !out_data.line_level && !out_data.send_rejected)
    else $error("idle result with line high or refusal");

endmodule

bind ir_pulse_distance_transmitter_core irpdt_checker u_irpdt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int KEY_W     = irpdt_pkg::KEY_W;
  localparam int LEN_W     = irpdt_pkg::LEN_W;
  localparam int CFG_IDX_W = irpdt_pkg::CFG_IDX_W;
  localparam int BIT_IDX_W = irpdt_pkg::BIT_IDX_W;
  localparam int SEL_W     = irpdt_pkg::SEL_W;

  localparam int NUM_REGS      = 5;
  localparam int MAX_GAP       = 12;
  localparam int HOLD_AFTER    = 30;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_TICKS   = 80;
  localparam int FRAME_PHASES  = 11;
  localparam int PHASE_ITEMS   = 40;
  localparam int WIDE_TICKS    = 20;

  // tracks the transmitted frame and holds the line/busy values still owed
  class frame_level_board;
    irpdt_pkg::cfg_regs_t lens;
    logic [KEY_W-1:0]     code_sr;
    logic [BIT_IDX_W-1:0] bit_pos;
    irpdt_pkg::seg_t      seg;
    logic [LEN_W-1:0]     ticks;
    logic                 line;
    logic                 busy;
    irpdt_pkg::out_t      owed_levels[$];
    int unsigned          errors;

    function new();
      lens.header_high_len = irpdt_pkg::HEADER_HIGH_RST;
      lens.header_low_len  = irpdt_pkg::HEADER_LOW_RST;
      lens.mark_len        = irpdt_pkg::MARK_RST;
      lens.one_len         = irpdt_pkg::ONE_RST;
      lens.zero_len        = irpdt_pkg::ZERO_RST;
      code_sr = '0;
      bit_pos = irpdt_pkg::HDR_IDX;
      seg     = irpdt_pkg::SEG_HDR_HIGH;
      ticks   = '0;
      line    = 1'b0;
      busy    = 1'b0;
      errors  = 0;
    endfunction

    function void set_len(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] value);
      case (idx)
        irpdt_pkg::REG_HEADER_HIGH: lens.header_high_len = value;
        irpdt_pkg::REG_HEADER_LOW:  lens.header_low_len  = value;
        irpdt_pkg::REG_MARK:        lens.mark_len        = value;
        irpdt_pkg::REG_ONE:         lens.one_len         = value;
        irpdt_pkg::REG_ZERO:        lens.zero_len        = value;
        default: ;
      endcase
    endfunction

    function logic [LEN_W-1:0] segment_len();
      if (bit_pos == irpdt_pkg::HDR_IDX) begin
        case (seg)
          irpdt_pkg::SEG_HDR_HIGH: return lens.header_high_len;
          irpdt_pkg::SEG_HDR_LOW:  return lens.header_low_len;
          default:                 return lens.mark_len;
        endcase
      end
      if (seg == irpdt_pkg::SEG_DATA) begin
        return code_sr[bit_pos[SEL_W-1:0]] ? lens.one_len : lens.zero_len;
      end
      return lens.mark_len;
    endfunction

    function void close_segment();
      line = ~line;
      if (bit_pos == irpdt_pkg::HDR_IDX) begin
        case (seg)
          irpdt_pkg::SEG_HDR_HIGH: seg = irpdt_pkg::SEG_HDR_LOW;
          irpdt_pkg::SEG_HDR_LOW:  seg = irpdt_pkg::SEG_MARK;
          default: begin
            bit_pos = irpdt_pkg::LAST_IDX;
            seg     = irpdt_pkg::SEG_DATA;
          end
        endcase
      end else if (seg == irpdt_pkg::SEG_DATA) begin
        seg = irpdt_pkg::SEG_MARK;
      end else if (bit_pos == '0) begin
        // last mark done: line back low, frame over
        bit_pos = irpdt_pkg::HDR_IDX;
        seg     = irpdt_pkg::SEG_HDR_HIGH;
        busy    = 1'b0;
        code_sr = '0;
        line    = 1'b0;
      end else begin
        bit_pos = bit_pos - 1'b1;
        seg     = irpdt_pkg::SEG_DATA;
      end
    endfunction

    function irpdt_pkg::out_t advance(irpdt_pkg::in_t item);
      irpdt_pkg::out_t r;
      r = '0;
      if (item.op == irpdt_pkg::OP_SEND) begin
        if (busy) begin
          r.send_rejected = 1'b1;
        end else begin
          code_sr = item.keycode;
          busy    = 1'b1;
          bit_pos = irpdt_pkg::HDR_IDX;
          seg     = irpdt_pkg::SEG_HDR_HIGH;
          ticks   = '0;
          line    = 1'b1;
        end
      end else if (busy) begin
        // 16-bit compare timer: a lowered length wraps through zero
        if (ticks == segment_len()) begin
          ticks = '0;
          close_segment();
        end else begin
          ticks = ticks + 1'b1;
        end
      end
      r.line_level = line;
      r.busy_res   = busy;
      return r;
    endfunction

    function void note_transfer(irpdt_pkg::in_t item);
      owed_levels.push_back(advance(item));
    endfunction

    function void check_result(irpdt_pkg::out_t got);
      irpdt_pkg::out_t want;
      if (owed_levels.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result: line %0b busy %0b rejected %0b",
                   got.line_level, got.busy_res, got.send_rejected);
        end
        return;
      end
      want = owed_levels.pop_front();
      if (got.line_level !== want.line_level || got.busy_res !== want.busy_res ||
          got.send_rejected !== want.send_rejected) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: line/busy/rejected expected %0b/%0b/%0b, got %0b/%0b/%0b",
                   $realtime, want.line_level, want.busy_res, want.send_rejected,
                   got.line_level, got.busy_res, got.send_rejected);
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  irpdt_pkg::in_t       in_data;
  logic                 out_valid;
  logic                 out_ready;
  irpdt_pkg::out_t      out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEN_W-1:0]     cfg_data;

  frame_level_board     board;
  bit                   send_gaps_on;
  bit                   take_gaps_on;
  bit                   hold_done;
  int unsigned          results_taken;

  ir_pulse_distance_transmitter_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_transfer(in_data);
      if (out_valid && out_ready) begin
        board.check_result(out_data);
        results_taken++;
      end
    end
  end

  // result side: random stalls, plus one long hold so the block backs up
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && results_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        gap = HOLD_CYCLES;
      end else begin
        gap = take_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic irpdt_pkg::in_t make_tick(logic [KEY_W-1:0] key);
    irpdt_pkg::in_t item;
    item.op      = irpdt_pkg::OP_TICK;
    item.keycode = key;
    return item;
  endfunction

  function automatic irpdt_pkg::in_t make_send(logic [KEY_W-1:0] key);
    irpdt_pkg::in_t item;
    item.op      = irpdt_pkg::OP_SEND;
    item.keycode = key;
    return item;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return KEY_W'(1) << $urandom_range(0, KEY_W - 1);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return '0;
      7:          return LEN_W'($urandom_range(3, 6));
      default:    return LEN_W'($urandom_range(1, 2));
    endcase
  endfunction

  task automatic offer(irpdt_pkg::in_t item);
    int gap;
    gap = send_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_len(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_len(idx, value);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // stop sending and let every owed result come out
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.owed_levels.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    int idx;
    int phase;
    logic [LEN_W-1:0] len;
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_gaps_on = 1'b1;
    take_gaps_on = 1'b1;
    hold_done = 1'b0;
    results_taken = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset lengths: idle ticks, a send, sends while busy, a few ticks
    offer(make_tick('0));
    offer(make_tick('1));
    offer(make_send('1));
    offer(make_send('0));
    repeat (3) offer(make_tick($urandom()));
    offer(make_send(32'h5a5a_a5a5));
    settle();

    // header ends at the running count, short bits finish the frame;
    // writes past the last register are dropped
    write_len(irpdt_pkg::REG_HEADER_HIGH, board.ticks);
    write_len(irpdt_pkg::REG_HEADER_LOW, '0);
    write_len(irpdt_pkg::REG_MARK, '0);
    write_len(irpdt_pkg::REG_ONE, '0);
    write_len(irpdt_pkg::REG_ZERO, '1);
    for (idx = NUM_REGS; idx < (1 << CFG_IDX_W); idx++) begin
      write_len(CFG_IDX_W'(idx), LEN_W'(idx));
    end
    end_writes();
    send_gaps_on = 1'b0;
    take_gaps_on = 1'b0;
    repeat (DRAIN_TICKS) offer(make_tick($urandom()));
    settle();

    for (phase = 0; phase < FRAME_PHASES; phase++) begin
      // never below the running count, so no wrap here
      for (idx = 0; idx < NUM_REGS; idx++) begin
        len = pick_len();
        if (len < board.ticks) len = board.ticks;
        write_len(CFG_IDX_W'(idx), len);
      end
      end_writes();
      send_gaps_on = ($urandom_range(0, 3) != 0);
      take_gaps_on = ($urandom_range(0, 3) != 0);
      repeat (PHASE_ITEMS) begin
        if ((!board.busy && $urandom_range(0, 1) == 0) ||
            (board.busy && $urandom_range(0, 39) == 0)) begin
          offer(make_send(pick_key()));
        end else begin
          offer(make_tick($urandom()));
        end
      end
      settle();
    end

    // widest lengths, frame just under way
    for (idx = 0; idx < NUM_REGS; idx++) write_len(CFG_IDX_W'(idx), '1);
    end_writes();
    send_gaps_on = 1'b1;
    take_gaps_on = 1'b1;
    offer(make_send(pick_key()));
    repeat (WIDE_TICKS) offer(make_tick($urandom()));
    settle();

    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
